/* rtl/tpf_pkg.sv */
// Shared types and constants of the five-tuple packet filter.
package tpf_pkg;

    localparam int MAX_RULES = 64;
    localparam int RULE_W    = $clog2(MAX_RULES);
    localparam int CNT_W     = $clog2(MAX_RULES + 1);

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_DEL    = 2'd1;
    localparam logic [1:0] KIND_CLS    = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_NOPOS = 2'd2;

    localparam logic [1:0] PC_ANY    = 2'd0;
    localparam logic [1:0] PC_TCP    = 2'd1;
    localparam logic [1:0] PC_UDP    = 2'd2;
    localparam logic [1:0] PC_ANY_HI = 2'd3;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    typedef struct packed {
        logic [1:0]  kind;
        logic        direction;
        logic [31:0] src_addr;
        logic [31:0] src_mask;
        logic [15:0] src_l4_port;
        logic [31:0] dst_addr;
        logic [31:0] dst_mask;
        logic [15:0] dst_port;
        logic [1:0]  proto_code;
        logic        drop_action;
        logic [7:0]  packet_proto;
        logic [6:0]  position;
    } t_item;

    typedef struct packed {
        logic       verdict;
        logic [6:0] drop_rule;
        logic [1:0] status;
        logic [6:0] rule_total;
    } t_result;

    // One stored rule, as held in the rule memory.
    typedef struct packed {
        logic        direction;
        logic [15:0] src_l4_port;
        logic [15:0] dst_port;
        logic [1:0]  proto_code;
        logic        drop_action;
        logic [31:0] src_addr;
        logic [31:0] src_mask;
        logic [31:0] dst_addr;
        logic [31:0] dst_mask;
    } t_rule;

    localparam int RULE_BITS = $bits(t_rule);

endpackage

/* rtl/tpf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/tpf_front.sv */
// Front end: accept items, zero ports of non-TCP/UDP packets, two-entry queue.
module tpf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tpf_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output tpf_pkg::t_item o_head
);

    tpf_pkg::t_item r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    tpf_pkg::t_item n_item;
    logic           push_ok;
    logic           pop_ok;

    always_comb begin
        n_item = i_item;
        // Ports only count for TCP and UDP packets.
        if (i_item.kind == tpf_pkg::KIND_CLS &&
            i_item.packet_proto != tpf_pkg::PROTO_TCP &&
            i_item.packet_proto != tpf_pkg::PROTO_UDP) begin
            n_item.src_l4_port = '0;
            n_item.dst_port    = '0;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= n_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push_ok) - 2'(pop_ok);
        end
    end

endmodule

/* rtl/tpf_back.sv */
// Back end: rule table sequencer for add, delete shift and classify scan.
module tpf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  tpf_pkg::t_item   i_head,
    output logic             o_take,
    output logic             o_empty,
    input  logic             i_pop,
    output tpf_pkg::t_result o_result
);

    typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_DRAIN, S_SCAN} t_state;

    t_state                       r_state;
    logic [tpf_pkg::CNT_W-1:0]    r_total;
    logic [tpf_pkg::CNT_W-1:0]    r_idx;
    logic [tpf_pkg::RULE_W-1:0]   r_tag;
    logic [tpf_pkg::RULE_W-1:0]   r_wa;
    logic                         r_pend;
    tpf_pkg::t_item               r_cmd;
    logic                         r_out_valid;
    tpf_pkg::t_result             r_res;

    logic                         we;
    logic [tpf_pkg::RULE_W-1:0]   waddr;
    logic [tpf_pkg::RULE_BITS-1:0] wdata;
    logic [tpf_pkg::RULE_BITS-1:0] rdata;
    tpf_pkg::t_rule               rule_rd;
    tpf_pkg::t_rule               rule_new;
    logic                         hit;
    logic                         src_ok;
    logic                         dst_ok;
    logic                         proto_ok;

    assign o_take   = (r_state == S_IDLE) && i_valid && !r_out_valid;
    assign o_empty  = !r_out_valid;
    assign o_result = r_res;
    assign rule_rd  = tpf_pkg::t_rule'(rdata);

    always_comb begin
        rule_new.direction   = i_head.direction;
        rule_new.src_l4_port = i_head.src_l4_port;
        rule_new.dst_port    = i_head.dst_port;
        rule_new.proto_code  = i_head.proto_code;
        rule_new.drop_action = i_head.drop_action;
        rule_new.src_addr    = i_head.src_addr;
        rule_new.src_mask    = i_head.src_mask;
        rule_new.dst_addr    = i_head.dst_addr;
        rule_new.dst_mask    = i_head.dst_mask;
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_total[tpf_pkg::RULE_W-1:0];
        wdata = rule_new;
        if (o_take && i_head.kind == tpf_pkg::KIND_ADD &&
            r_total < tpf_pkg::CNT_W'(tpf_pkg::MAX_RULES)) begin
            we = 1'b1;
        end else if (r_pend && (r_state == S_SHIFT || r_state == S_DRAIN)) begin
            we    = 1'b1;
            waddr = r_wa;
            wdata = rdata;
        end
    end

    // Match the rule read last cycle against the packet held in r_cmd.
    always_comb begin
        src_ok = (rule_rd.src_addr == '0) ||
                 ((r_cmd.src_addr & rule_rd.src_mask) ==
                  (rule_rd.src_addr & rule_rd.src_mask));
        dst_ok = (rule_rd.dst_addr == '0) ||
                 ((r_cmd.dst_addr & rule_rd.dst_mask) ==
                  (rule_rd.dst_addr & rule_rd.dst_mask));
        proto_ok = !((rule_rd.proto_code == tpf_pkg::PC_TCP &&
                      r_cmd.packet_proto != tpf_pkg::PROTO_TCP) ||
                     (rule_rd.proto_code == tpf_pkg::PC_UDP &&
                      r_cmd.packet_proto != tpf_pkg::PROTO_UDP));
        hit = (rule_rd.direction == r_cmd.direction) && proto_ok && src_ok && dst_ok &&
              (rule_rd.src_l4_port == '0 || rule_rd.src_l4_port == r_cmd.src_l4_port) &&
              (rule_rd.dst_port == '0 || rule_rd.dst_port == r_cmd.dst_port) &&
              !rule_rd.drop_action;
    end

    tpf_ram #(
        .WIDTH (tpf_pkg::RULE_BITS),
        .DEPTH (tpf_pkg::MAX_RULES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx[tpf_pkg::RULE_W-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_take) begin
                        r_cmd           <= i_head;
                        r_pend          <= 1'b0;
                        r_res.verdict   <= 1'b0;
                        r_res.drop_rule <= '0;
                        case (i_head.kind)
                            tpf_pkg::KIND_ADD: begin
                                r_out_valid <= 1'b1;
                                if (r_total < tpf_pkg::CNT_W'(tpf_pkg::MAX_RULES)) begin
                                    r_total          <= r_total + 1'b1;
                                    r_res.status     <= tpf_pkg::STAT_DONE;
                                    r_res.rule_total <= r_total + 1'b1;
                                end else begin
                                    r_res.status     <= tpf_pkg::STAT_FULL;
                                    r_res.rule_total <= r_total;
                                end
                            end
                            tpf_pkg::KIND_DEL: begin
                                if (i_head.position == '0 || i_head.position > r_total) begin
                                    r_res.status     <= tpf_pkg::STAT_NOPOS;
                                    r_res.rule_total <= r_total;
                                    r_out_valid      <= 1'b1;
                                end else if (i_head.position == r_total) begin
                                    r_total          <= r_total - 1'b1;
                                    r_res.status     <= tpf_pkg::STAT_DONE;
                                    r_res.rule_total <= r_total - 1'b1;
                                    r_out_valid      <= 1'b1;
                                end else begin
                                    r_res.status <= tpf_pkg::STAT_DONE;
                                    r_idx        <= i_head.position;
                                    r_state      <= S_SHIFT;
                                end
                            end
                            tpf_pkg::KIND_CLS: begin
                                r_res.status     <= tpf_pkg::STAT_DONE;
                                r_res.rule_total <= r_total;
                                r_idx            <= '0;
                                r_state          <= S_SCAN;
                            end
                            default: begin
                                r_res.status     <= tpf_pkg::STAT_DONE;
                                r_res.rule_total <= r_total;
                                r_out_valid      <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SHIFT: begin
                    // Read entry r_idx, write it one place lower next cycle.
                    r_pend <= 1'b1;
                    r_wa   <= r_idx[tpf_pkg::RULE_W-1:0] - 1'b1;
                    r_idx  <= r_idx + 1'b1;
                    if (r_idx + 1'b1 == r_total) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_pend           <= 1'b0;
                    r_total          <= r_total - 1'b1;
                    r_res.rule_total <= r_total - 1'b1;
                    r_out_valid      <= 1'b1;
                    r_state          <= S_IDLE;
                end
                S_SCAN: begin
                    if (r_pend && hit) begin
                        r_res.verdict   <= 1'b1;
                        r_res.drop_rule <= 7'(r_tag) + 7'd1;
                        r_pend          <= 1'b0;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end else if (r_idx < r_total) begin
                        r_pend <= 1'b1;
                        r_tag  <= r_idx[tpf_pkg::RULE_W-1:0];
                        r_idx  <= r_idx + 1'b1;
                    end else begin
                        r_pend      <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/five_tuple_packet_filter.sv */
// Top level of the five-tuple packet filter: front queue, rule engine, rule memory.
//
//  channel  | transfer when      | payload
//  ---------+--------------------+---------------------------------------
//  item in  | push && !full      | i_item  (tpf_pkg::t_item)
//  result   | pop && !empty      | o_result (tpf_pkg::t_result)
//
// An item enters the queue on its transfer. Add, kind 3, a delete at the last
// position and a delete out of range show their result in the cycle after
// leaving the head. A delete elsewhere moves each later rule one place lower
// through the single rule memory port pair, then drains. Classify reads one
// rule per cycle, stopping at the first drop hit.
// Reset (synchronous, active low) empties the queue and the rule count; the
// rule memory needs no clearing. A waiting result holds the engine, while the
// two-entry queue keeps taking items until it fills.
module five_tuple_packet_filter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  tpf_pkg::t_item   i_item,
    output logic             empty,
    input  logic             pop,
    output tpf_pkg::t_result o_result
);

    tpf_pkg::t_item q_head;
    logic           q_valid;
    logic           q_take;

    // Accept and queue items.
    tpf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_pop   (q_take),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // Carry out each item against the rule table and hold its result.
    tpf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_head   (q_head),
        .o_take   (q_take),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (o_result)
    );

endmodule

/* bench/tb_five_tuple_packet_filter.sv */
// Self-checking testbench of the five-tuple packet filter: directed and random items.
module tb_five_tuple_packet_filter;
    timeunit 1ns;
    timeprecision 1ps;

    // Rule table mirror and the verdicts it yields, checked in transfer order.
    class filter_scoreboard;
        tpf_pkg::t_item rules[$];
        tpf_pkg::t_result pending[$];
        int errors;

        function void note_item(tpf_pkg::t_item it);
            tpf_pkg::t_result res;
            tpf_pkg::t_item pk;
            logic [15:0] sp, dp;
            logic hit;
            res = '0;
            case (it.kind)
                tpf_pkg::KIND_ADD: begin
                    if (rules.size() >= tpf_pkg::MAX_RULES) res.status = tpf_pkg::STAT_FULL;
                    else rules.push_back(it);
                end
                tpf_pkg::KIND_DEL: begin
                    if (it.position == 0 || it.position > rules.size())
                        res.status = tpf_pkg::STAT_NOPOS;
                    else rules.delete(it.position - 1);
                end
                tpf_pkg::KIND_CLS: begin
                    sp = it.src_l4_port;
                    dp = it.dst_port;
                    // Ports only count for TCP and UDP packets.
                    if (it.packet_proto != tpf_pkg::PROTO_TCP &&
                        it.packet_proto != tpf_pkg::PROTO_UDP) begin
                        sp = '0;
                        dp = '0;
                    end
                    foreach (rules[r]) begin
                        pk = rules[r];
                        hit = pk.direction == it.direction;
                        if (pk.proto_code == tpf_pkg::PC_TCP &&
                            it.packet_proto != tpf_pkg::PROTO_TCP) hit = 1'b0;
                        if (pk.proto_code == tpf_pkg::PC_UDP &&
                            it.packet_proto != tpf_pkg::PROTO_UDP) hit = 1'b0;
                        if (pk.src_addr != 0 &&
                            (it.src_addr & pk.src_mask) != (pk.src_addr & pk.src_mask))
                            hit = 1'b0;
                        if (pk.dst_addr != 0 &&
                            (it.dst_addr & pk.dst_mask) != (pk.dst_addr & pk.dst_mask))
                            hit = 1'b0;
                        if (pk.src_l4_port != 0 && pk.src_l4_port != sp) hit = 1'b0;
                        if (pk.dst_port != 0 && pk.dst_port != dp) hit = 1'b0;
                        if (hit && !pk.drop_action) begin
                            res.verdict = 1'b1;
                            res.drop_rule = 7'(r + 1);
                            break;
                        end
                    end
                end
                default: ;
            endcase
            res.rule_total = 7'(rules.size());
            pending.push_back(res);
        endfunction

        function void check_result(tpf_pkg::t_result got);
            tpf_pkg::t_result exp;
            if (pending.size() == 0) begin
                $error("result with nothing expected: %p", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.verdict !== exp.verdict) begin
                $error("verdict: expected %0d, got %0d", exp.verdict, got.verdict); errors++;
            end
            if (got.drop_rule !== exp.drop_rule) begin
                $error("drop_rule: expected %0d, got %0d", exp.drop_rule, got.drop_rule); errors++;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status); errors++;
            end
            if (got.rule_total !== exp.rule_total) begin
                $error("rule_total: expected %0d, got %0d", exp.rule_total, got.rule_total);
                errors++;
            end
        endfunction
    endclass

    logic    i_clk = 0;
    logic    i_rst_n = 0;
    logic    push = 0;
    logic    pop = 0;
    logic    full, empty;
    tpf_pkg::t_item   i_item = '0;
    tpf_pkg::t_result o_result;

    filter_scoreboard sb = new();
    int cycle_count = 0;
    bit calm = 0;   // stretch with no idling on either side

    five_tuple_packet_filter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_result(o_result)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Drain side: check each transfer, stall pop at random.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && pop && !empty) sb.check_result(o_result);
        pop <= calm || ($urandom_range(99) >= 14);
    end

    // A small pool of addresses and ports so that packets actually hit rules.
    function automatic logic [31:0] pick_addr();
        case ($urandom_range(3))
            0: return 32'h0;
            1: return {24'h0a0000, 6'h0, 2'($urandom_range(3))};
            2: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_mask();
        case ($urandom_range(3))
            0: return 32'hffffffff;
            1: return 32'hffffff00;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(3))
            0: return 16'h0;
            1: return 16'd80 + 16'($urandom_range(1));
            2: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic tpf_pkg::t_item random_item(logic [1:0] k);
        tpf_pkg::t_item it;
        it = '0;
        it.kind = k;
        it.direction = 1'($urandom_range(1));
        it.src_addr = pick_addr();
        it.src_mask = pick_mask();
        it.src_l4_port = pick_port();
        it.dst_addr = pick_addr();
        it.dst_mask = pick_mask();
        it.dst_port = pick_port();
        it.proto_code = 2'($urandom_range(3));
        it.drop_action = 1'($urandom_range(1));
        case ($urandom_range(3))
            0: it.packet_proto = tpf_pkg::PROTO_TCP;
            1: it.packet_proto = tpf_pkg::PROTO_UDP;
            default: it.packet_proto = 8'($urandom);
        endcase
        it.position = $urandom_range(3) == 0 ? 7'($urandom) :
                      7'($urandom_range(sb.rules.size() + 1));
        return it;
    endfunction

    // Offer one item and hold it until the block takes it; idle at random first.
    task automatic send_item(tpf_pkg::t_item it);
        while (!calm && $urandom_range(99) < 14) begin
            push <= 0;
            @(posedge i_clk);
        end
        push <= 1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        sb.note_item(it);
    endtask

    task automatic send_kind(logic [1:0] k);
        send_item(random_item(k));
    endtask

    task automatic wait_drained();
        push <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    tpf_pkg::t_item di;

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty-table cases, extremes, every kind and special case.
        di = '0; di.kind = tpf_pkg::KIND_DEL; di.position = 0; send_item(di);
        di.position = 7'h7f;                               send_item(di);
        di = '1; di.kind = tpf_pkg::KIND_CLS;              send_item(di);
        di = '1; di.kind = tpf_pkg::KIND_UNUSED;           send_item(di);
        di = '0; di.kind = tpf_pkg::KIND_ADD;              send_item(di); // catch-all drop
        di = '1; di.kind = tpf_pkg::KIND_ADD; di.proto_code = tpf_pkg::PC_TCP;
        di.drop_action = 0;
        send_item(di);
        di = '0; di.kind = tpf_pkg::KIND_CLS;              send_item(di);
        di = '1; di.kind = tpf_pkg::KIND_CLS; di.packet_proto = tpf_pkg::PROTO_TCP;
        send_item(di);
        di.packet_proto = tpf_pkg::PROTO_UDP;              send_item(di);
        di = '0; di.kind = tpf_pkg::KIND_ADD; di.direction = 1;
        di.proto_code = tpf_pkg::PC_ANY_HI;
        di.src_l4_port = 16'd53; di.drop_action = 0;       send_item(di);
        di = '0; di.kind = tpf_pkg::KIND_CLS; di.direction = 1; di.packet_proto = 8'd1;
        di.src_l4_port = 16'd53;                           send_item(di); // ports zeroed
        di.packet_proto = tpf_pkg::PROTO_UDP;              send_item(di);
        di = '0; di.kind = tpf_pkg::KIND_DEL; di.position = 1; send_item(di);
        di.position = 2;                                   send_item(di); // last position
        di.position = 7'd64;                               send_item(di);
        wait_drained();

        // Fill to the limit, overflow, then delete from the middle and both ends.
        while (sb.rules.size() < tpf_pkg::MAX_RULES) send_kind(tpf_pkg::KIND_ADD);
        send_kind(tpf_pkg::KIND_ADD);
        send_kind(tpf_pkg::KIND_CLS);
        di = '0; di.kind = tpf_pkg::KIND_DEL; di.position = 7'd64; send_item(di);
        di.position = 7'd1;                                send_item(di);
        di.position = 7'd30;                               send_item(di);

        // Random part; pause once until drained, and keep a calm stretch.
        for (int n = 0; n < 1800; n++) begin
            if (n == 600) wait_drained();
            calm = (n >= 900 && n < 1100);
            case ($urandom_range(9))
                0, 1, 2: send_kind(tpf_pkg::KIND_ADD);
                3, 4:    send_kind(tpf_pkg::KIND_DEL);
                5:       send_kind($urandom_range(3) == 0 ? tpf_pkg::KIND_UNUSED
                                                           : tpf_pkg::KIND_CLS);
                default: send_kind(tpf_pkg::KIND_CLS);
            endcase
        end
        calm = 0;
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[five_tuple_packet_filter] OK");
        end else begin
            $display("[five_tuple_packet_filter] ERROR");
        end
        $finish;
    end

    // Hard limit on the run length.
    initial begin
        wait (cycle_count >= 2000000);
        $display("[five_tuple_packet_filter] ERROR");
        $finish;
    end
endmodule
